// File: rtl/ffwsa_pkg.sv
package ffwsa_pkg;

   // field widths
   localparam int SLOT_W    = 5;
   localparam int DUR_W     = 6;
   localparam int PEN_W     = 8;
   localparam int TOTAL_W   = 16;
   localparam int HORIZON_W = 6;

   localparam logic [HORIZON_W-1:0] HORIZON_RESET = 6'd20;

   // scan sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // one request
   typedef struct packed {
      logic               new_order;
      logic [SLOT_W-1:0]  window_start;
      logic [SLOT_W-1:0]  window_end;
      logic [DUR_W-1:0]   duration;
      logic [PEN_W-1:0]   task_penalty;
   } task_type;

   // one result
   typedef struct packed {
      logic               placed;
      logic [SLOT_W-1:0]  start_slot;
      logic [TOTAL_W-1:0] total_penalty;
   } result_type;

   // engine status towards the stream side
   typedef struct packed {
      logic ready;
      logic done;
   } status_type;

endpackage

// File: rtl/ffwsa_engine.sv
module ffwsa_engine
   import ffwsa_pkg::*;
#(
   parameter int SLOTS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  task_type             task_req,
   input  logic [HORIZON_W-1:0] horizon,
   input  logic                 take,
   output status_type           status,
   output result_type           result
);

   localparam int         IW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [6:0] SLOTS_W = 7'(SLOTS);

   state_type          state_ff, state_in;
   task_type           task_ff, task_in;
   logic [6:0]         hz_ff, hz_in;
   logic [5:0]         s_ff, s_in;
   logic [5:0]         run_ff, run_in;
   logic [SLOTS-1:0]   occ_ff, occ_in;
   logic [TOTAL_W-1:0] pen_ff, pen_in;
   result_type         res_ff, res_in;

   logic [6:0]         hz_eff;
   logic [5:0]         first_slot;
   logic [16:0]        pen_sum;
   logic [TOTAL_W-1:0] pen_sat;
   logic               slot_busy;
   logic               zero_fit;

   // effective horizon is capped at the bitmap size
   assign hz_eff = ({1'b0, horizon} > SLOTS_W) ? SLOTS_W : {1'b0, horizon};

   // saturating penalty add
   assign pen_sum = {1'b0, pen_ff} + 17'(task_ff.task_penalty);
   assign pen_sat = pen_sum[16] ? {TOTAL_W{1'b1}} : pen_sum[TOTAL_W-1:0];

   assign slot_busy  = occ_ff[s_ff[IW-1:0]];
   assign first_slot = s_ff - run_ff;
   assign zero_fit   = ({1'b0, task_ff.window_start} <= ({1'b0, task_ff.window_end} + 6'd1))
                       && ({2'b0, task_ff.window_start} <= hz_ff);

   // state and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         occ_ff   <= '0;
         pen_ff   <= '0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
         pen_ff   <= pen_in;
      end
      task_ff <= task_in;
      hz_ff   <= hz_in;
      s_ff    <= s_in;
      run_ff  <= run_in;
      res_ff  <= res_in;
   end

   // sequencer: one slot examined per cycle
   always_comb begin
      state_in = state_ff;
      task_in  = task_ff;
      hz_in    = hz_ff;
      s_in     = s_ff;
      run_in   = run_ff;
      occ_in   = occ_ff;
      pen_in   = pen_ff;
      res_in   = res_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               task_in  = task_req;
               hz_in    = hz_eff;
               s_in     = {1'b0, task_req.window_start};
               run_in   = '0;
               state_in = ST_SCAN;
               if (task_req.new_order) begin
                  occ_in = '0;
                  pen_in = '0;
               end
            end
         end
         ST_SCAN: begin
            state_in = ST_DONE;
            priority if (task_ff.duration == '0) begin
               // zero length run takes no slot
               if (zero_fit) begin
                  res_in.placed     = 1'b1;
                  res_in.start_slot = task_ff.window_start;
               end else begin
                  pen_in            = pen_sat;
                  res_in.placed     = 1'b0;
                  res_in.start_slot = '0;
               end
               res_in.total_penalty = zero_fit ? pen_ff : pen_sat;
            end else if ((s_ff > {1'b0, task_ff.window_end}) || ({1'b0, s_ff} >= hz_ff)) begin
               // ran past window or horizon
               pen_in               = pen_sat;
               res_in.placed        = 1'b0;
               res_in.start_slot    = '0;
               res_in.total_penalty = pen_sat;
            end else if (slot_busy) begin
               run_in   = '0;
               s_in     = s_ff + 6'd1;
               state_in = ST_SCAN;
            end else if ((7'(run_ff) + 7'd1) == {1'b0, task_ff.duration}) begin
               // free run complete: mark first_slot..s busy
               for (int i = 0; i < SLOTS; i++) begin
                  if ((7'(i) >= {1'b0, first_slot}) && (7'(i) <= {1'b0, s_ff})) begin
                     occ_in[i] = 1'b1;
                  end
               end
               res_in.placed        = 1'b1;
               res_in.start_slot    = first_slot[SLOT_W-1:0];
               res_in.total_penalty = pen_ff;
            end else begin
               run_in   = run_ff + 6'd1;
               s_in     = s_ff + 6'd1;
               state_in = ST_SCAN;
            end
         end
         ST_DONE: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign status.ready = (state_ff == ST_IDLE);
   assign status.done  = (state_ff == ST_DONE);
   assign result       = res_ff;

endmodule

// File: rtl/first_fit_window_slot_allocator_core.sv
// first-fit window slot allocator
// requests enter on req_*: req_tuser is the new-order flag (clears the slot
// bitmap and the penalty total before the task), req_tdata carries the window,
// duration and penalty. each request gives exactly one result on rsp_*, in order.
// rsp_tuser is the placed flag, rsp_tdata the start slot and running penalty.
// csr_wr_en/csr_wr_data write the horizon (slots in use); the user writes it only
// while idle, which the block does not enforce. after the accept, the scan
// sequencer examines one slot per cycle, from window_start up to one past the
// window end or horizon, then the result is loaded into the output register. one
// request is in work at a time: req_tready is high only while the scan sequencer
// is idle, so a new request is taken only once the last result has left it.
// a finished result sits in the output register; a new request can be taken
// while it waits, and the next result is held in the sequencer until rsp_tready.
// reset (synchronous): bitmap free, penalty total zero, horizon 20, no result.
module first_fit_window_slot_allocator_core
   import ffwsa_pkg::*;
#(
   parameter int SLOTS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // window_start[4:0], window_end[9:5], duration[15:10],
                                    // task_penalty[23:16]
   input  logic [0:0]  req_tuser,   // new_order[0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // start_slot[4:0], total_penalty[20:5], zero[23:21]
   output logic [0:0]  rsp_tuser,   // placed[0]
   // horizon register
   input  logic        csr_wr_en,
   input  logic [5:0]  csr_wr_data
);

   logic [HORIZON_W-1:0] horizon_ff, horizon_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   result_type           rsp_res_ff, rsp_res_in;
   task_type             task_req;
   status_type           eng_status;
   result_type           eng_result;
   logic                 req_fire;
   logic                 take;

   // unpack request
   assign task_req.new_order    = req_tuser[0];
   assign task_req.window_start = req_tdata[4:0];
   assign task_req.window_end   = req_tdata[9:5];
   assign task_req.duration     = req_tdata[15:10];
   assign task_req.task_penalty = req_tdata[23:16];

   assign req_tready = eng_status.ready;
   assign req_fire   = req_tvalid & eng_status.ready;
   assign take       = eng_status.done & (~rsp_tvalid_ff | rsp_tready);

   ffwsa_engine #(
      .SLOTS (SLOTS)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .start    (req_fire),
      .task_req (task_req),
      .horizon  (horizon_ff),
      .take     (take),
      .status   (eng_status),
      .result   (eng_result)
   );

   // horizon register and output stage
   always_comb begin
      horizon_in    = csr_wr_en ? csr_wr_data : horizon_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_res_in    = rsp_res_ff;
      if (take) begin
         rsp_tvalid_in = 1'b1;
         rsp_res_in    = eng_result;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         horizon_ff    <= HORIZON_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         horizon_ff    <= horizon_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {3'b000, rsp_res_ff.total_penalty, rsp_res_ff.start_slot};
   assign rsp_tuser  = rsp_res_ff.placed;

endmodule

// File: rtl/ffwsa_checker.sv
module ffwsa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // reset leaves no result pending
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // one request in work: ready drops after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken during scan");

   // a penalised task reports start slot zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[4:0] == 5'd0)
      else $error("unplaced result with nonzero start");

   // a fresh result never follows an accept in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result appeared without scan");

endmodule

bind first_fit_window_slot_allocator_core ffwsa_checker u_ffwsa_checker (.*);
